// File: src/tsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared constants, codes and control/status types of the thermal monitor.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 64;

  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned PROD_W  = TIME_W + MAG_W;

  localparam logic signed [TEMP_W-1:0] TEMP_CEILING = 16'sd2400;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_OVER_TEMP   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MIN_VALID   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_CHG_WINDOW  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_MAX_CHANGE  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_HP_LEVEL    = 3'd4;
  localparam logic [CIDX_W-1:0] REG_HTR_TIMEOUT = 3'd5;
  localparam logic [CIDX_W-1:0] REG_MIN_RISE    = 3'd6;
  localparam logic [CIDX_W-1:0] REG_HIST_SPAN   = 3'd7;

  // fault codes
  localparam logic [2:0] FLT_NONE     = 3'd0;
  localparam logic [2:0] FLT_OVERTEMP = 3'd1;
  localparam logic [2:0] FLT_DISCONN  = 3'd2;
  localparam logic [2:0] FLT_DROP     = 3'd3;
  localparam logic [2:0] FLT_RUNAWAY  = 3'd4;
  localparam logic [2:0] FLT_HEATER   = 3'd5;

  // source of the past temperature
  localparam logic [2:0] THEN_NONE   = 3'd0;
  localparam logic [2:0] THEN_FIRST  = 3'd1;
  localparam logic [2:0] THEN_LAST   = 3'd2;
  localparam logic [2:0] THEN_PREV   = 3'd3;
  localparam logic [2:0] THEN_INTERP = 3'd4;

  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic       load_in;
    logic       clear;
    logic       drop_oldest;
    logic       write_hist;
    logic       rd_scan;
    logic       k_init;
    logic       k_inc;
    logic       save_prev;
    logic       interp_setup;
    logic       mul;
    logic       div_start;
    logic       heater_upd;
    logic       fault_set;
    logic [2:0] fault_code;
    logic [2:0] then_sel;
    logic       out_load;
  } tsm_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic safe;
    logic count_full;
    logic count_ge2;
    logic count_zero;
    logic prune_en;
    logic prune_hit;
    logic first_hit;
    logic last_hit;
    logic scan_hit;
    logic k_end;
    logic span_zero;
    logic f_over;
    logic f_inv;
    logic rate_drop;
    logic rate_rise;
    logic no_heat_rise;
    logic div_done;
  } tsm_status_t;

endpackage

// File: src/tsm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_in_if / tsm_out_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface tsm_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [31:0]        timestamp_ms;
  logic signed [15:0] temperature;
  logic               reading_invalid;
  logic [6:0]         heater_duty;

  modport source (output valid, operation, timestamp_ms, temperature,
                  reading_invalid, heater_duty, input ready);
  modport sink   (input valid, operation, timestamp_ms, temperature,
                  reading_invalid, heater_duty, output ready);
endinterface

interface tsm_out_if;
  logic               valid;
  logic               ready;
  logic               safe;
  logic [2:0]         fault_code;
  logic signed [15:0] latest_temp;
  logic               latest_temp_valid;

  modport source (output valid, safe, fault_code, latest_temp, latest_temp_valid,
                  input ready);
  modport sink   (input valid, safe, fault_code, latest_temp, latest_temp_valid,
                  output ready);
endinterface

// File: src/thermal_safety_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_safety_monitor_top
// Thermal safety monitor: sample history, rate, limit and heater checks.
// ----------------------------------------------------------------------------
// Sequence per word: clear and latched-fault words go straight to the result;
// sample words are written to history, then pruned when pruning is on, scanned
// with two or more entries and interpolated by the divider (one quotient bit a
// cycle) when needed; an early fault cuts it short, a waiting result adds stall.
// Throughput: one word at a time; a new word is taken while the result waits.
// Reset: synchronous active-low; configuration and state registers return to defaults, history empty.
module thermal_safety_monitor_top #(
  parameter int unsigned HISTORY_DEPTH = tsm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tsm_in_if.sink                     in_s,
  tsm_out_if.source                  out_s,
  input  logic                       cfg_we,
  input  logic [tsm_pkg::CIDX_W-1:0] cfg_idx,
  input  logic [tsm_pkg::CFG_W-1:0]  cfg_wdata
);
  import tsm_pkg::*;

  tsm_cmd_t    cmd;
  tsm_status_t st;

  tsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .st        (st),
    .cmd       (cmd)
  );

  tsm_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_idx               (cfg_idx),
    .cfg_wdata             (cfg_wdata),
    .in_operation          (in_s.operation),
    .in_timestamp_ms       (in_s.timestamp_ms),
    .in_temperature        (in_s.temperature),
    .in_reading_invalid    (in_s.reading_invalid),
    .in_heater_duty        (in_s.heater_duty),
    .out_safe              (out_s.safe),
    .out_fault_code        (out_s.fault_code),
    .out_latest_temp       (out_s.latest_temp),
    .out_latest_temp_valid (out_s.latest_temp_valid),
    .cmd                   (cmd),
    .st                    (st)
  );

endmodule

// File: src/tsm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/tsm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tsm_pkg::PROD_W-1:0] dividend,
  input  logic [tsm_pkg::TIME_W-1:0] divisor,
  output logic                       done,
  output logic [tsm_pkg::PROD_W-1:0] quotient
);
  import tsm_pkg::*;

  localparam int unsigned NW = PROD_W;
  localparam int unsigned DW = TIME_W;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    dvs_r, dvs_nxt;
  logic [DW:0]      rem_sh;
  logic [DW:0]      rem_diff;
  logic             ge;

  assign rem_sh   = {rem_r, quo_r[NW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign ge       = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: src/tsm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_datapath
// Registers, history RAM, interpolation and fault checks of the monitor.
// ----------------------------------------------------------------------------
module tsm_datapath #(
  parameter int unsigned HISTORY_DEPTH = tsm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [tsm_pkg::CIDX_W-1:0] cfg_idx,
  input  logic [tsm_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_operation,
  input  logic [31:0]                in_timestamp_ms,
  input  logic signed [15:0]         in_temperature,
  input  logic                       in_reading_invalid,
  input  logic [6:0]                 in_heater_duty,
  output logic                       out_safe,
  output logic [2:0]                 out_fault_code,
  output logic signed [15:0]         out_latest_temp,
  output logic                       out_latest_temp_valid,
  input  tsm_pkg::tsm_cmd_t          cmd,
  output tsm_pkg::tsm_status_t       st
);
  import tsm_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned RW = TEMP_W + TIME_W;

  // configuration
  logic signed [15:0] over_lim_r;
  logic signed [15:0] min_valid_r;
  logic [15:0]        window_r;
  logic [14:0]        max_change_r;
  logic [6:0]         hp_level_r;
  logic [23:0]        timeout_r;
  logic [14:0]        min_rise_r;
  logic [15:0]        span_cfg_r;

  // captured word
  logic               op_r;
  logic [31:0]        now_r;
  logic signed [15:0] temp_r;
  logic               inv_r;
  logic [6:0]         duty_r;

  // monitor state
  logic [AW-1:0]      head_r;
  logic [CW-1:0]      count_r;
  logic               ni_r;
  logic signed [15:0] latest_r;
  logic               safe_r;
  logic [2:0]         fault_r;
  logic               hp_active_r;
  logic [31:0]        hp_since_r;
  logic signed [15:0] hp_base_r;

  // interpolation
  logic [CW-1:0]      k_r;
  logic [31:0]        prev_t_r;
  logic signed [15:0] prev_temp_r;
  logic signed [15:0] then_r;
  logic [31:0]        dt_r;
  logic [31:0]        span_r;
  logic [MAG_W-1:0]   mag_r;
  logic               neg_r;
  logic [PROD_W-1:0]  prod_r;

  // output word
  logic               o_safe_r;
  logic [2:0]         o_fault_r;
  logic signed [15:0] o_temp_r;
  logic               o_valid_r;

  logic [RW-1:0]      rdata;
  logic [31:0]        rd_t;
  logic signed [15:0] rd_temp;
  logic [CW:0]        wsum, ksum;
  logic [AW-1:0]      wslot, kslot, raddr, head_inc;
  logic [31:0]        target, cutoff;
  logic               div_done;
  logic [PROD_W-1:0]  quo;
  logic signed [16:0] dtemp, qs, isum, hrise;
  logic signed [17:0] delta, mc;
  logic               hp_cond, elapsed, rise_lt, lat_valid;

  assign rd_t    = rdata[TIME_W-1:0];
  assign rd_temp = rdata[RW-1:TIME_W];

  // ring index arithmetic, operands stay below twice the depth
  assign wsum  = {1'b0, CW'(head_r)} + {1'b0, count_r};
  assign ksum  = {1'b0, CW'(head_r)} + {1'b0, k_r};
  assign wslot = (wsum >= (CW+1)'(HISTORY_DEPTH)) ?
                 AW'(wsum - (CW+1)'(HISTORY_DEPTH)) : AW'(wsum);
  assign kslot = (ksum >= (CW+1)'(HISTORY_DEPTH)) ?
                 AW'(ksum - (CW+1)'(HISTORY_DEPTH)) : AW'(ksum);
  assign head_inc = (head_r == AW'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign raddr = cmd.rd_scan ? kslot : head_r;

  assign target = now_r - {16'b0, window_r};
  assign cutoff = now_r - {16'b0, span_cfg_r};

  tsm_ram #(.WIDTH(RW), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (cmd.write_hist),
    .waddr (wslot),
    .wdata ({temp_r, now_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  tsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (span_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign dtemp = {rd_temp[15], rd_temp} - {prev_temp_r[15], prev_temp_r};
  assign qs    = neg_r ? -$signed({1'b0, quo[MAG_W-1:0]}) : $signed({1'b0, quo[MAG_W-1:0]});
  assign isum  = {prev_temp_r[15], prev_temp_r} + qs;
  assign delta = {{2{latest_r[15]}}, latest_r} - {{2{then_r[15]}}, then_r};
  assign mc    = $signed({3'b0, max_change_r});

  assign hp_cond = duty_r >= hp_level_r;
  assign elapsed = (now_r - hp_since_r) >= {8'b0, timeout_r};
  assign hrise   = {temp_r[15], temp_r} - {hp_base_r[15], hp_base_r};
  assign rise_lt = hrise < $signed({2'b0, min_rise_r});

  assign lat_valid = (count_r != '0) && !ni_r;

  always_comb begin
    st.op_clear     = op_r == OP_CLEAR;
    st.safe         = safe_r;
    st.count_full   = count_r >= CW'(HISTORY_DEPTH);
    st.count_ge2    = count_r >= CW'(2);
    st.count_zero   = count_r == '0;
    st.prune_en     = now_r >= {16'b0, span_cfg_r};
    st.prune_hit    = (count_r != '0) && (rd_t < cutoff);
    st.first_hit    = target <= rd_t;
    st.last_hit     = target >= now_r;
    st.scan_hit     = rd_t >= target;
    st.k_end        = k_r == count_r;
    st.span_zero    = rd_t == prev_t_r;
    st.f_over       = !inv_r && (temp_r > over_lim_r);
    st.f_inv        = inv_r || (temp_r < min_valid_r) || (temp_r > TEMP_CEILING);
    st.rate_drop    = delta < -mc;
    st.rate_rise    = delta > mc;
    st.no_heat_rise = hp_cond && hp_active_r && elapsed && rise_lt;
    st.div_done     = div_done;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      over_lim_r   <= 16'sd880;
      min_valid_r  <= 16'sd0;
      window_r     <= 16'd2000;
      max_change_r <= 15'd80;
      hp_level_r   <= 7'd80;
      timeout_r    <= 24'd600000;
      min_rise_r   <= 15'd32;
      span_cfg_r   <= 16'd5000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OVER_TEMP:   over_lim_r   <= cfg_wdata[15:0];
        REG_MIN_VALID:   min_valid_r  <= cfg_wdata[15:0];
        REG_CHG_WINDOW:  window_r     <= cfg_wdata[15:0];
        REG_MAX_CHANGE:  max_change_r <= cfg_wdata[14:0];
        REG_HP_LEVEL:    hp_level_r   <= cfg_wdata[6:0];
        REG_HTR_TIMEOUT: timeout_r    <= cfg_wdata[23:0];
        REG_MIN_RISE:    min_rise_r   <= cfg_wdata[14:0];
        REG_HIST_SPAN:   span_cfg_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // monitor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      ni_r        <= 1'b0;
      safe_r      <= 1'b1;
      fault_r     <= FLT_NONE;
      hp_active_r <= 1'b0;
      hp_since_r  <= '0;
      hp_base_r   <= '0;
    end else begin
      if (cmd.clear) begin
        head_r      <= '0;
        count_r     <= '0;
        ni_r        <= 1'b0;
        safe_r      <= 1'b1;
        fault_r     <= FLT_NONE;
        hp_active_r <= 1'b0;
        hp_since_r  <= '0;
        hp_base_r   <= '0;
      end
      if (cmd.drop_oldest) begin
        head_r  <= head_inc;
        count_r <= count_r - 1'b1;
      end
      if (cmd.write_hist) begin
        count_r <= count_r + 1'b1;
        ni_r    <= inv_r;
      end
      if (cmd.fault_set) begin
        safe_r  <= 1'b0;
        fault_r <= cmd.fault_code;
      end
      if (cmd.heater_upd) begin
        if (hp_cond) begin
          if (!hp_active_r) begin
            hp_active_r <= 1'b1;
            hp_since_r  <= now_r;
            hp_base_r   <= temp_r;
          end else if (elapsed && !rise_lt) begin
            hp_since_r <= now_r;
            hp_base_r  <= temp_r;
          end
        end else begin
          hp_active_r <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_operation;
      now_r  <= in_timestamp_ms;
      temp_r <= in_temperature;
      inv_r  <= in_reading_invalid;
      duty_r <= in_heater_duty;
    end
    if (cmd.write_hist) begin
      latest_r <= temp_r;
    end
    if (cmd.k_init) begin
      k_r <= CW'(1);
    end else if (cmd.k_inc) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.save_prev) begin
      prev_t_r    <= rd_t;
      prev_temp_r <= rd_temp;
    end
    if (cmd.interp_setup) begin
      dt_r   <= target - prev_t_r;
      span_r <= rd_t - prev_t_r;
      neg_r  <= dtemp[16];
      mag_r  <= dtemp[16] ? MAG_W'(-dtemp) : MAG_W'(dtemp);
    end
    if (cmd.mul) begin
      prod_r <= dt_r * mag_r;
    end
    unique case (cmd.then_sel)
      THEN_NONE:   ;
      THEN_FIRST:  then_r <= rd_temp;
      THEN_LAST:   then_r <= latest_r;
      THEN_PREV:   then_r <= prev_temp_r;
      THEN_INTERP: then_r <= isum[15:0];
      default: ;
    endcase
    if (cmd.out_load) begin
      o_safe_r  <= safe_r;
      o_fault_r <= fault_r;
      o_valid_r <= lat_valid;
      o_temp_r  <= lat_valid ? latest_r : 16'sd0;
    end
  end

  assign out_safe              = o_safe_r;
  assign out_fault_code        = o_fault_r;
  assign out_latest_temp       = o_temp_r;
  assign out_latest_temp_valid = o_valid_r;

endmodule

// File: src/tsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_ctrl
// Sequencer: history update, pruning, window scan, divide and fault checks.
// ----------------------------------------------------------------------------
module tsm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tsm_pkg::tsm_status_t st,
  output tsm_pkg::tsm_cmd_t    cmd
);
  import tsm_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECIDE    = 4'd1;
  localparam logic [3:0] S_WRITE     = 4'd2;
  localparam logic [3:0] S_PRUNE_RD  = 4'd3;
  localparam logic [3:0] S_PRUNE_CMP = 4'd4;
  localparam logic [3:0] S_CHECK     = 4'd5;
  localparam logic [3:0] S_FIRST     = 4'd6;
  localparam logic [3:0] S_SCAN_RD   = 4'd7;
  localparam logic [3:0] S_SCAN_CMP  = 4'd8;
  localparam logic [3:0] S_MUL       = 4'd9;
  localparam logic [3:0] S_DIV       = 4'd10;
  localparam logic [3:0] S_DIV_WAIT  = 4'd11;
  localparam logic [3:0] S_RATE      = 4'd12;
  localparam logic [3:0] S_HEATER    = 4'd13;
  localparam logic [3:0] S_OUT       = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.op_clear) begin
          cmd.clear = 1'b1;
          state_nxt = S_OUT;
        end else if (!st.safe) begin
          state_nxt = S_OUT;
        end else begin
          cmd.drop_oldest = st.count_full;
          state_nxt       = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_hist = 1'b1;
        state_nxt      = st.prune_en ? S_PRUNE_RD : S_CHECK;
      end
      S_PRUNE_RD: state_nxt = S_PRUNE_CMP;
      S_PRUNE_CMP: begin
        if (st.prune_hit) begin
          cmd.drop_oldest = 1'b1;
          state_nxt       = S_PRUNE_RD;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // oldest entry is read here for the window lookup
        priority if (st.f_over) begin
          cmd.fault_set  = 1'b1;
          cmd.fault_code = FLT_OVERTEMP;
          state_nxt      = S_OUT;
        end else if (st.f_inv) begin
          cmd.fault_set  = 1'b1;
          cmd.fault_code = FLT_DISCONN;
          state_nxt      = S_OUT;
        end else if (st.count_ge2) begin
          state_nxt = S_FIRST;
        end else begin
          state_nxt = S_HEATER;
        end
      end
      S_FIRST: begin
        priority if (st.first_hit) begin
          cmd.then_sel = THEN_FIRST;
          state_nxt    = S_RATE;
        end else if (st.last_hit) begin
          cmd.then_sel = THEN_LAST;
          state_nxt    = S_RATE;
        end else begin
          cmd.save_prev = 1'b1;
          cmd.k_init    = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (st.k_end) begin
          cmd.then_sel = THEN_LAST;
          state_nxt    = S_RATE;
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt   = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        priority if (st.scan_hit && st.span_zero) begin
          cmd.then_sel = THEN_PREV;
          state_nxt    = S_RATE;
        end else if (st.scan_hit) begin
          cmd.interp_setup = 1'b1;
          state_nxt        = S_MUL;
        end else begin
          cmd.save_prev = 1'b1;
          cmd.k_inc     = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (st.div_done) begin
          cmd.then_sel = THEN_INTERP;
          state_nxt    = S_RATE;
        end
      end
      S_RATE: begin
        priority if (st.rate_drop) begin
          cmd.fault_set  = 1'b1;
          cmd.fault_code = FLT_DROP;
          state_nxt      = S_OUT;
        end else if (st.rate_rise) begin
          cmd.fault_set  = 1'b1;
          cmd.fault_code = FLT_RUNAWAY;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_HEATER;
        end
      end
      S_HEATER: begin
        cmd.heater_upd = 1'b1;
        if (st.no_heat_rise) begin
          cmd.fault_set  = 1'b1;
          cmd.fault_code = FLT_HEATER;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_r || out_ready) begin
          cmd.out_load = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

  a_write_only_safe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_hist |-> st.safe)
    else $error("history written while a fault is latched");

  a_drop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop_oldest |-> !st.count_zero)
    else $error("drop from empty history");

  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DECIDE)
    else $error("accepted word not decoded");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!ovalid_r || out_ready))
    else $error("result overwritten before taken");

endmodule
